@@ hdl/gdmq_pkg.sv @@
// ----------------------------------------------------------------------------
// gdmq_pkg
// shared types, codes and step tables of the grid distance map query unit
// ----------------------------------------------------------------------------
package gdmq_pkg;

  localparam int unsigned STRAIGHT_COST = 10;
  localparam int unsigned DIAG_COST     = 14;
  localparam int unsigned COST_W        = 10;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_ALLOW_DIAG = 2'd0,
    CFG_MAX_LENGTH = 2'd1,
    CFG_START_X    = 2'd2,
    CFG_START_Y    = 2'd3
  } cfg_idx_e;

  // one cost store entry
  typedef struct packed {
    logic              reached;
    logic [COST_W-1:0] cost;
  } cost_entry_t;

  // neighbor order: left, right, up, down, then the four diagonals
  function automatic logic signed [1:0] step_dx(input logic [2:0] k);
    logic signed [1:0] r;
    case (k)
      3'd0, 3'd4, 3'd5: r = -2'sd1;
      3'd1, 3'd6, 3'd7: r = 2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] step_dy(input logic [2:0] k);
    logic signed [1:0] r;
    case (k)
      3'd2, 3'd4, 3'd6: r = -2'sd1;
      3'd3, 3'd5, 3'd7: r = 2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/grid_distance_map_nearest_query_unit.sv @@
// ----------------------------------------------------------------------------
// grid_distance_map_nearest_query_unit
// load: writes one passability bit. query: goes straight to the result when
// out of window or before a build, else reads the cell itself and, if it is
// unreached, scans the rings out to RING_RADIUS; build: clears the whole cost
// store, writes the start cell, then sweeps the region reading each cell and
// its neighbors until a sweep changes nothing; the cost store has one read port
// reset sets control and configuration to defaults; the stores are not reset
// ----------------------------------------------------------------------------
module grid_distance_map_nearest_query_unit #(
  parameter int unsigned GRID        = 64,
  parameter int unsigned RING_RADIUS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [5:0] cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [5:0] cell_x_i,
  input  logic [5:0] cell_y_i,
  input  logic       passable_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       found_o,
  output logic       exact_o,
  output logic [8:0] path_cost_o,
  output logic [5:0] best_x_o,
  output logic [5:0] best_y_o
);

  localparam int unsigned CB    = $clog2(GRID);
  localparam int unsigned CELLS = GRID * GRID;
  localparam int unsigned AW    = $clog2(CELLS);
  // signed coordinate width, room for ring offsets past the window edge
  localparam int unsigned CW    = ((CB > 6) ? CB : 6) + 2;
  localparam int unsigned DW    = $clog2(RING_RADIUS + 1);
  localparam int unsigned EW    = $bits(gdmq_pkg::cost_entry_t);
  localparam int unsigned KW    = 4;

  localparam logic signed [CW-1:0] GRID_M1 = CW'(GRID - 1);
  localparam logic [AW-1:0]        CLR_LAST = AW'(CELLS - 1);
  localparam logic [DW-1:0]        RING_LAST = DW'(RING_RADIUS);

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_CLEAR    = 10'b00_0000_0010,
    ST_START_RD = 10'b00_0000_0100,
    ST_START_WR = 10'b00_0000_1000,
    ST_SWEEP    = 10'b00_0001_0000,
    ST_SWEEP_WR = 10'b00_0010_0000,
    ST_Q_CENTER = 10'b00_0100_0000,
    ST_Q_RING   = 10'b00_1000_0000,
    ST_Q_LAST   = 10'b01_0000_0000,
    ST_DONE     = 10'b10_0000_0000
  } state_e;

  typedef logic signed [CW-1:0] coord_t;

  function automatic logic [AW-1:0] cell_addr(input coord_t x, input coord_t y);
    logic [AW-1:0] row;
    row = AW'(AW'(y[CB-1:0]) * AW'(GRID));
    return row + AW'(x[CB-1:0]);
  endfunction

  function automatic logic in_grid(input coord_t x, input coord_t y);
    return (x >= 0) && (y >= 0) && (x <= GRID_M1) && (y <= GRID_M1);
  endfunction

  // ---------------------------------------------------------------- registers
  state_e state_q, state_d;

  logic       allow_diag_q;
  logic [4:0] max_length_q;
  logic [5:0] start_x_q, start_y_q;
  logic       map_built_q, map_built_d;
  logic       changed_q, changed_d;

  logic [AW-1:0] clr_q, clr_d;

  // build region and cost cutoff, latched at build start
  coord_t     x0_q, x1_q, y0_q, y1_q, x0_d, x1_d, y0_d, y1_d;
  logic [8:0] limit_q, limit_d;

  // cell under relaxation and its read step
  coord_t                      vx_q, vy_q, vx_d, vy_d;
  logic [KW-1:0]               k_q, k_d;
  logic                        cur_pass_q, cur_pass_d;
  logic                        cur_reached_q, cur_reached_d;
  logic [gdmq_pkg::COST_W-1:0] cur_cost_q, cur_cost_d;
  logic                        acc_have_q, acc_have_d;
  logic [gdmq_pkg::COST_W-1:0] acc_cost_q, acc_cost_d;

  // tag of the read in flight
  logic   tag_vld_q, tag_vld_d;
  logic   tag_center_q, tag_center_d;
  logic   tag_diag_q, tag_diag_d;
  coord_t tag_x_q, tag_y_q, tag_x_d, tag_y_d;

  // query walk
  coord_t                      qx_q, qy_q, qx_d, qy_d;
  logic [DW-1:0]               d_q, d_d;
  logic                        ph_q, ph_d;
  logic                        s_q, s_d;
  coord_t                      t_q, t_d;
  logic                        best_have_q, best_have_d;
  logic                        exact_q, exact_d;
  logic [gdmq_pkg::COST_W-1:0] best_cost_q, best_cost_d;
  coord_t                      best_x_q, best_y_q, best_x_d, best_y_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic       found_q, found_d;
  logic       exact_out_q, exact_out_d;
  logic [8:0] cost_out_q, cost_out_d;
  logic [5:0] bx_out_q, by_out_q, bx_out_d, by_out_d;

  // ---------------------------------------------------------------- memories
  logic                  pass_we;
  logic [AW-1:0]         pass_waddr, pass_raddr;
  logic                  pass_rdata;
  logic                  cost_we;
  logic [AW-1:0]         cost_waddr, cost_raddr;
  gdmq_pkg::cost_entry_t cost_wdata, cost_rdata;
  logic [EW-1:0]         cost_rdata_raw;

  gdmq_ram #(.WIDTH(1), .DEPTH(CELLS)) u_pass_ram (
    .clk_i   (clk_i),
    .we_i    (pass_we),
    .waddr_i (pass_waddr),
    .wdata_i (passable_i),
    .raddr_i (pass_raddr),
    .rdata_o (pass_rdata)
  );

  gdmq_ram #(.WIDTH(EW), .DEPTH(CELLS)) u_cost_ram (
    .clk_i   (clk_i),
    .we_i    (cost_we),
    .waddr_i (cost_waddr),
    .wdata_i (cost_wdata),
    .raddr_i (cost_raddr),
    .rdata_o (cost_rdata_raw)
  );

  assign cost_rdata = gdmq_pkg::cost_entry_t'(cost_rdata_raw);

  // ---------------------------------------------------------------- helpers
  logic   in_acc;
  coord_t in_x, in_y, sx, sy, ml;
  logic   start_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_x       = coord_t'(cell_x_i);
  assign in_y       = coord_t'(cell_y_i);
  assign sx         = coord_t'(start_x_q);
  assign sy         = coord_t'(start_y_q);
  assign ml         = coord_t'(max_length_q);
  assign start_ok   = in_grid(sx, sy);

  // neighbor of the cell under relaxation for the current read step
  logic [2:0]    nbr_k;
  coord_t        nx, ny;
  logic          n_in_region;
  logic [KW-1:0] k_last;

  assign nbr_k       = 3'(k_q - KW'(1));
  assign nx          = vx_q + coord_t'(gdmq_pkg::step_dx(nbr_k));
  assign ny          = vy_q + coord_t'(gdmq_pkg::step_dy(nbr_k));
  assign n_in_region = (nx >= x0_q) && (nx <= x1_q) && (ny >= y0_q) && (ny <= y1_q);
  assign k_last      = allow_diag_q ? KW'(8) : KW'(4);

  // candidate cost through the neighbor whose data just came back
  logic                        cand_ok;
  logic [gdmq_pkg::COST_W-1:0] cand_cost;
  logic                        fin_have;
  logic [gdmq_pkg::COST_W-1:0] fin_cost;

  always_comb begin
    cand_cost = cost_rdata.cost + (tag_diag_q ? gdmq_pkg::COST_W'(gdmq_pkg::DIAG_COST)
                                              : gdmq_pkg::COST_W'(gdmq_pkg::STRAIGHT_COST));
    cand_ok   = tag_vld_q && cost_rdata.reached &&
                (cost_rdata.cost <= gdmq_pkg::COST_W'(limit_q));
    fin_have  = acc_have_q;
    fin_cost  = acc_cost_q;
    if (cand_ok && (!acc_have_q || (cand_cost < acc_cost_q))) begin
      fin_have = 1'b1;
      fin_cost = cand_cost;
    end
  end

  // ring cell for the current walk position
  coord_t dd, rx, ry;
  logic   ring_end;

  always_comb begin
    dd = coord_t'(d_q);
    if (!ph_q) begin
      rx = qx_q + t_q;
      ry = s_q ? (qy_q + dd) : (qy_q - dd);
    end else begin
      rx = s_q ? (qx_q + dd) : (qx_q - dd);
      ry = qy_q + t_q;
    end
    ring_end = (d_q == RING_LAST) && ph_q && (t_q == dd - coord_t'(1)) && s_q;
  end

  // ring hit: reached cell strictly cheaper than the best so far
  logic ring_hit;
  assign ring_hit = tag_vld_q && cost_rdata.reached &&
                    (!best_have_q || (cost_rdata.cost < best_cost_q));

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d       = state_q;
    map_built_d   = map_built_q;
    changed_d     = changed_q;
    clr_d         = clr_q;
    x0_d          = x0_q;
    x1_d          = x1_q;
    y0_d          = y0_q;
    y1_d          = y1_q;
    limit_d       = limit_q;
    vx_d          = vx_q;
    vy_d          = vy_q;
    k_d           = k_q;
    cur_pass_d    = cur_pass_q;
    cur_reached_d = cur_reached_q;
    cur_cost_d    = cur_cost_q;
    acc_have_d    = acc_have_q;
    acc_cost_d    = acc_cost_q;
    tag_vld_d     = 1'b0;
    tag_center_d  = 1'b0;
    tag_diag_d    = 1'b0;
    tag_x_d       = tag_x_q;
    tag_y_d       = tag_y_q;
    qx_d          = qx_q;
    qy_d          = qy_q;
    d_d           = d_q;
    ph_d          = ph_q;
    s_d           = s_q;
    t_d           = t_q;
    best_have_d   = best_have_q;
    exact_d       = exact_q;
    best_cost_d   = best_cost_q;
    best_x_d      = best_x_q;
    best_y_d      = best_y_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    found_d       = found_q;
    exact_out_d   = exact_out_q;
    cost_out_d    = cost_out_q;
    bx_out_d      = bx_out_q;
    by_out_d      = by_out_q;

    pass_we    = 1'b0;
    pass_waddr = cell_addr(in_x, in_y);
    pass_raddr = cell_addr(vx_q, vy_q);
    cost_we    = 1'b0;
    cost_waddr = cell_addr(vx_q, vy_q);
    cost_wdata = '0;
    cost_raddr = cell_addr(vx_q, vy_q);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (gdmq_pkg::op_e'(operation_i))
            gdmq_pkg::OP_LOAD: begin
              pass_we = in_grid(in_x, in_y);
            end
            gdmq_pkg::OP_BUILD: begin
              // region clipped to the window, cutoff in scaled units
              x0_d      = (sx - ml < 0) ? coord_t'(0) : sx - ml;
              y0_d      = (sy - ml < 0) ? coord_t'(0) : sy - ml;
              x1_d      = (sx + ml > GRID_M1) ? GRID_M1 : sx + ml;
              y1_d      = (sy + ml > GRID_M1) ? GRID_M1 : sy + ml;
              limit_d   = 9'(max_length_q) * 9'(gdmq_pkg::STRAIGHT_COST);
              clr_d     = '0;
              changed_d = 1'b0;
              state_d   = ST_CLEAR;
            end
            gdmq_pkg::OP_QUERY: begin
              qx_d        = in_x;
              qy_d        = in_y;
              best_have_d = 1'b0;
              exact_d     = 1'b0;
              best_cost_d = '0;
              best_x_d    = '0;
              best_y_d    = '0;
              if (map_built_q && in_grid(in_x, in_y)) begin
                state_d = ST_Q_CENTER;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      // every cell goes back to unreached
      ST_CLEAR: begin
        cost_we    = 1'b1;
        cost_waddr = clr_q;
        clr_d      = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_START_RD;
        end
      end

      ST_START_RD: begin
        pass_raddr = cell_addr(sx, sy);
        state_d    = ST_START_WR;
      end

      ST_START_WR: begin
        if (start_ok && pass_rdata) begin
          cost_we    = 1'b1;
          cost_waddr = cell_addr(sx, sy);
          cost_wdata = '{reached: 1'b1, cost: '0};
          vx_d       = x0_q;
          vy_d       = y0_q;
          k_d        = '0;
          changed_d  = 1'b0;
          state_d    = ST_SWEEP;
        end else begin
          // start not usable: nothing is reached
          map_built_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      // step 0 reads the cell itself, later steps read its neighbors
      ST_SWEEP: begin
        if (k_q == '0) begin
          cost_raddr   = cell_addr(vx_q, vy_q);
          tag_center_d = 1'b1;
          acc_have_d   = 1'b0;
          acc_cost_d   = '0;
        end else begin
          cost_raddr = cell_addr(nx, ny);
          tag_vld_d  = n_in_region;
          tag_diag_d = nbr_k[2];
          acc_have_d = fin_have;
          acc_cost_d = fin_cost;
        end
        if (tag_center_q) begin
          cur_pass_d    = pass_rdata;
          cur_reached_d = cost_rdata.reached;
          cur_cost_d    = cost_rdata.cost;
        end
        k_d = k_q + KW'(1);
        if (k_q == k_last) begin
          state_d = ST_SWEEP_WR;
        end
      end

      ST_SWEEP_WR: begin
        k_d = '0;
        if (cur_pass_q && fin_have && (!cur_reached_q || (fin_cost < cur_cost_q))) begin
          cost_we    = 1'b1;
          cost_waddr = cell_addr(vx_q, vy_q);
          cost_wdata = '{reached: 1'b1, cost: fin_cost};
          changed_d  = 1'b1;
        end
        state_d = ST_SWEEP;
        if (vx_q == x1_q) begin
          vx_d = x0_q;
          if (vy_q == y1_q) begin
            vy_d = y0_q;
            // another sweep only if something moved
            if (changed_q || changed_d) begin
              changed_d = 1'b0;
            end else begin
              map_built_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end else begin
            vy_d = vy_q + coord_t'(1);
          end
        end else begin
          vx_d = vx_q + coord_t'(1);
        end
      end

      ST_Q_CENTER: begin
        cost_raddr   = cell_addr(qx_q, qy_q);
        tag_center_d = 1'b1;
        d_d          = DW'(1);
        ph_d         = 1'b0;
        s_d          = 1'b0;
        t_d          = -coord_t'(1);
        state_d      = ST_Q_RING;
      end

      // one ring cell read per cycle, checked in the cycle after its read
      ST_Q_RING: begin
        if (tag_center_q && cost_rdata.reached) begin
          best_have_d = 1'b1;
          exact_d     = 1'b1;
          best_cost_d = cost_rdata.cost;
          best_x_d    = qx_q;
          best_y_d    = qy_q;
          state_d     = ST_DONE;
        end else begin
          if (ring_hit) begin
            best_have_d = 1'b1;
            best_cost_d = cost_rdata.cost;
            best_x_d    = tag_x_q;
            best_y_d    = tag_y_q;
          end
          cost_raddr = cell_addr(rx, ry);
          tag_vld_d  = in_grid(rx, ry);
          tag_x_d    = rx;
          tag_y_d    = ry;
          if (!s_q) begin
            s_d = 1'b1;
          end else begin
            s_d = 1'b0;
            if (!ph_q && (t_q == dd)) begin
              ph_d = 1'b1;
              t_d  = coord_t'(1) - dd;
            end else if (ph_q && (t_q == dd - coord_t'(1))) begin
              ph_d = 1'b0;
              d_d  = d_q + DW'(1);
              t_d  = -(dd + coord_t'(1));
            end else begin
              t_d = t_q + coord_t'(1);
            end
          end
          if (ring_end) begin
            state_d = ST_Q_LAST;
          end
        end
      end

      ST_Q_LAST: begin
        if (ring_hit) begin
          best_have_d = 1'b1;
          best_cost_d = cost_rdata.cost;
          best_x_d    = tag_x_q;
          best_y_d    = tag_y_q;
        end
        state_d = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          found_d     = best_have_q;
          exact_out_d = best_have_q && exact_q;
          cost_out_d  = best_have_q ? best_cost_q[8:0] : 9'd0;
          bx_out_d    = best_have_q ? best_x_q[5:0] : 6'd0;
          by_out_d    = best_have_q ? best_y_q[5:0] : 6'd0;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      allow_diag_q <= 1'b1;
      max_length_q <= 5'd8;
      start_x_q    <= '0;
      start_y_q    <= '0;
      map_built_q  <= 1'b0;
      changed_q    <= 1'b0;
      tag_vld_q    <= 1'b0;
      tag_center_q <= 1'b0;
      tag_diag_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      map_built_q  <= map_built_d;
      changed_q    <= changed_d;
      tag_vld_q    <= tag_vld_d;
      tag_center_q <= tag_center_d;
      tag_diag_q   <= tag_diag_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (gdmq_pkg::cfg_idx_e'(cfg_index_i))
          gdmq_pkg::CFG_ALLOW_DIAG: allow_diag_q <= cfg_wdata_i[0];
          gdmq_pkg::CFG_MAX_LENGTH: max_length_q <= cfg_wdata_i[4:0];
          gdmq_pkg::CFG_START_X:    start_x_q    <= cfg_wdata_i;
          gdmq_pkg::CFG_START_Y:    start_y_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    clr_q         <= clr_d;
    x0_q          <= x0_d;
    x1_q          <= x1_d;
    y0_q          <= y0_d;
    y1_q          <= y1_d;
    limit_q       <= limit_d;
    vx_q          <= vx_d;
    vy_q          <= vy_d;
    k_q           <= k_d;
    cur_pass_q    <= cur_pass_d;
    cur_reached_q <= cur_reached_d;
    cur_cost_q    <= cur_cost_d;
    acc_have_q    <= acc_have_d;
    acc_cost_q    <= acc_cost_d;
    tag_x_q       <= tag_x_d;
    tag_y_q       <= tag_y_d;
    qx_q          <= qx_d;
    qy_q          <= qy_d;
    d_q           <= d_d;
    ph_q          <= ph_d;
    s_q           <= s_d;
    t_q           <= t_d;
    best_have_q   <= best_have_d;
    exact_q       <= exact_d;
    best_cost_q   <= best_cost_d;
    best_x_q      <= best_x_d;
    best_y_q      <= best_y_d;
    found_q       <= found_d;
    exact_out_q   <= exact_out_d;
    cost_out_q    <= cost_out_d;
    bx_out_q      <= bx_out_d;
    by_out_q      <= by_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign exact_o     = exact_out_q;
  assign path_cost_o = cost_out_q;
  assign best_x_o    = bx_out_q;
  assign best_y_o    = by_out_q;

endmodule

@@ hdl/gdmq_ram.sv @@
// ----------------------------------------------------------------------------
// gdmq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module gdmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/grid_distance_map_nearest_query_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_distance_map_nearest_query_unit_tb
// self-checking bench: loads tile passability, builds distance maps under
// several register settings and checks every query item against a local
// relaxation and ring-scan predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module grid_distance_map_nearest_query_unit_tb;

  localparam int GRID_N = 64;
  localparam int RING_N = 4;
  localparam int CELL_N = GRID_N * GRID_N;

  typedef struct {
    gdmq_pkg::op_e op;
    logic [5:0]    x;
    logic [5:0]    y;
    logic          pass;
  } tile_item_t;

  typedef struct packed {
    logic       found;
    logic       exact;
    logic [8:0] cost;
    logic [5:0] bx;
    logic [5:0] by;
  } query_res_t;

  // dut ports, known from time zero
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = gdmq_pkg::CFG_ALLOW_DIAG;
  logic [5:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] operation_i = gdmq_pkg::OP_LOAD;
  logic [5:0] cell_x_i = '0;
  logic [5:0] cell_y_i = '0;
  logic       passable_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       found_o;
  logic       exact_o;
  logic [8:0] path_cost_o;
  logic [5:0] best_x_o;
  logic [5:0] best_y_o;

  grid_distance_map_nearest_query_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .operation_i, .cell_x_i, .cell_y_i, .passable_i,
    .out_valid_o, .out_ready_i, .found_o, .exact_o, .path_cost_o,
    .best_x_o, .best_y_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the block: registers, passability and the built cost map
  bit         sh_diag = 1'b1;
  int         sh_maxlen = 8;
  int         sh_sx = 0;
  int         sh_sy = 0;
  bit         sh_pass [CELL_N];
  logic [9:0] sh_cost [CELL_N];
  bit         sh_reach [CELL_N];
  bit         sh_built = 1'b0;

  // generator side bookkeeping
  bit         loaded [CELL_N];
  tile_item_t tile_q [$];
  query_res_t expected_q [$];
  int         pending_items = 0;
  int         mismatches = 0;
  int         queries_seen = 0;
  int         builds_done = 0;
  bit         quiet = 1'b0;
  bit         hold_go = 1'b0;

  // relaxation sweeps in raster order until stable
  function automatic void build_costs();
    int x0, x1, y0, y1, x, y, k, nx, ny, u, v, moves;
    int dxs [8];
    int dys [8];
    int cst [8];
    int c, nc, lim;
    bit changed;
    dxs = '{-1, 1, 0, 0, -1, -1, 1, 1};
    dys = '{0, 0, -1, 1, -1, 1, -1, 1};
    cst = '{10, 10, 10, 10, 14, 14, 14, 14};
    lim = sh_maxlen * int'(gdmq_pkg::STRAIGHT_COST);
    for (int i = 0; i < CELL_N; i++) sh_reach[i] = 1'b0;
    sh_built = 1'b1;
    if (!sh_pass[sh_sy * GRID_N + sh_sx]) return;
    sh_reach[sh_sy * GRID_N + sh_sx] = 1'b1;
    sh_cost[sh_sy * GRID_N + sh_sx] = '0;
    x0 = (sh_sx - sh_maxlen < 0) ? 0 : sh_sx - sh_maxlen;
    y0 = (sh_sy - sh_maxlen < 0) ? 0 : sh_sy - sh_maxlen;
    x1 = (sh_sx + sh_maxlen > GRID_N - 1) ? GRID_N - 1 : sh_sx + sh_maxlen;
    y1 = (sh_sy + sh_maxlen > GRID_N - 1) ? GRID_N - 1 : sh_sy + sh_maxlen;
    moves = sh_diag ? 8 : 4;
    do begin
      changed = 1'b0;
      for (y = y0; y <= y1; y++)
        for (x = x0; x <= x1; x++) begin
          u = y * GRID_N + x;
          c = int'(sh_cost[u]);
          if (sh_reach[u] && c <= lim)
            for (k = 0; k < moves; k++) begin
              nx = x + dxs[k];
              ny = y + dys[k];
              nc = c + cst[k];
              if (nx >= x0 && nx <= x1 && ny >= y0 && ny <= y1) begin
                v = ny * GRID_N + nx;
                if (sh_pass[v] && (!sh_reach[v] || nc < int'(sh_cost[v]))) begin
                  sh_reach[v] = 1'b1;
                  sh_cost[v] = nc[9:0];
                  changed = 1'b1;
                end
              end
            end
        end
    end while (changed);
  endfunction

  // candidate in the ring scan, first found kept on equal cost
  function automatic void ring_cell(input int x, input int y, inout bit have,
                                    inout int best, inout int bx, inout int by);
    int i;
    if (x < 0 || y < 0 || x >= GRID_N || y >= GRID_N) return;
    i = y * GRID_N + x;
    if (!sh_reach[i]) return;
    if (!have || int'(sh_cost[i]) < best) begin
      have = 1'b1;
      best = int'(sh_cost[i]);
      bx = x;
      by = y;
    end
  endfunction

  function automatic query_res_t nearest_reached(input int x, input int y);
    query_res_t r;
    bit have;
    int best, bx, by;
    r = '0;
    have = 1'b0;
    best = 0;
    bx = 0;
    by = 0;
    if (!sh_built) return r;
    if (sh_reach[y * GRID_N + x]) begin
      r.found = 1'b1;
      r.exact = 1'b1;
      r.cost = sh_cost[y * GRID_N + x][8:0];
      r.bx = 6'(x);
      r.by = 6'(y);
      return r;
    end
    for (int d = 1; d <= RING_N; d++) begin
      for (int t = -d; t <= d; t++) begin
        ring_cell(x + t, y - d, have, best, bx, by);
        ring_cell(x + t, y + d, have, best, bx, by);
      end
      for (int t = -d + 1; t < d; t++) begin
        ring_cell(x - d, y + t, have, best, bx, by);
        ring_cell(x + d, y + t, have, best, bx, by);
      end
    end
    if (have) begin
      r.found = 1'b1;
      r.cost = best[8:0];
      r.bx = 6'(bx);
      r.by = 6'(by);
    end
    return r;
  endfunction

  // driver: presents queued items, updates the shadow on acceptance
  tile_item_t cur_item;
  int         in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pending_items--;
        case (cur_item.op)
          gdmq_pkg::OP_LOAD:  sh_pass[cur_item.y * GRID_N + cur_item.x] = cur_item.pass;
          gdmq_pkg::OP_BUILD: begin
            build_costs();
            builds_done++;
          end
          gdmq_pkg::OP_QUERY:
            expected_q = {expected_q, nearest_reached(int'(cur_item.x), int'(cur_item.y))};
          default: ;
        endcase
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (tile_q.size() > 0) begin
          cur_item = tile_q.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= cur_item.op;
          cell_x_i <= cur_item.x;
          cell_y_i <= cur_item.y;
          passable_i <= cur_item.pass;
          if (!quiet && $urandom_range(0, 4) == 0) in_gap = int'($urandom_range(1, 12));
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: random stalls, one long hold-off on request, field checks
  int out_gap = 0;
  int hold_cnt = 0;
  query_res_t got, want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{found_o, exact_o, path_cost_o, best_x_o, best_y_o};
        queries_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item %p", $time, got);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.found !== want.found || got.exact !== want.exact ||
              got.cost !== want.cost || got.bx !== want.bx || got.by !== want.by) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            mismatches++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else if (hold_go) begin
        hold_go = 1'b0;
        hold_cnt = 400;
        out_ready_i <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) out_gap = int'($urandom_range(1, 12));
      end
    end
  end

  task automatic add_item(input gdmq_pkg::op_e op, input int x, input int y, input bit p);
    tile_item_t it;
    it.op = op;
    it.x = 6'(x);
    it.y = 6'(y);
    it.pass = p;
    if (op == gdmq_pkg::OP_LOAD) loaded[y * GRID_N + x] = 1'b1;
    pending_items++;
    tile_q = {tile_q, it};
  endtask

  // every cell the build may look at must hold a loaded passability bit
  task automatic load_region(input int pass_pct);
    int x0, x1, y0, y1;
    x0 = (sh_sx - sh_maxlen < 0) ? 0 : sh_sx - sh_maxlen;
    y0 = (sh_sy - sh_maxlen < 0) ? 0 : sh_sy - sh_maxlen;
    x1 = (sh_sx + sh_maxlen > GRID_N - 1) ? GRID_N - 1 : sh_sx + sh_maxlen;
    y1 = (sh_sy + sh_maxlen > GRID_N - 1) ? GRID_N - 1 : sh_sy + sh_maxlen;
    for (int y = y0; y <= y1; y++)
      for (int x = x0; x <= x1; x++)
        if (!loaded[y * GRID_N + x])
          add_item(gdmq_pkg::OP_LOAD, x, y, int'($urandom_range(0, 99)) < pass_pct);
  endtask

  // a trailing query makes the block finish any build before we go idle
  task automatic drain();
    add_item(gdmq_pkg::OP_QUERY, sh_sx, sh_sy, 1'b0);
    wait (pending_items == 0 && expected_q.size() == 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_regs(input bit diag, input int ml, input int sx, input int sy);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= gdmq_pkg::CFG_ALLOW_DIAG; cfg_wdata_i <= 6'(diag);
    @(posedge clk_i);
    cfg_index_i <= gdmq_pkg::CFG_MAX_LENGTH; cfg_wdata_i <= 6'(ml);
    @(posedge clk_i);
    cfg_index_i <= gdmq_pkg::CFG_START_X; cfg_wdata_i <= 6'(sx);
    @(posedge clk_i);
    cfg_index_i <= gdmq_pkg::CFG_START_Y; cfg_wdata_i <= 6'(sy);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sh_diag = diag;
    sh_maxlen = ml;
    sh_sx = sx;
    sh_sy = sy;
  endtask

  // mostly near the start, sometimes anywhere in the window
  function automatic int near_coord(input int s);
    int v;
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, GRID_N - 1));
    v = s + int'($urandom_range(0, 2 * (sh_maxlen + RING_N))) - (sh_maxlen + RING_N);
    return (v < 0) ? 0 : (v > GRID_N - 1) ? GRID_N - 1 : v;
  endfunction

  task automatic random_items(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = int'($urandom_range(0, 99));
      if (r < 30)
        add_item(gdmq_pkg::OP_LOAD, near_coord(sh_sx), near_coord(sh_sy),
                 $urandom_range(0, 3) != 0);
      else if (r < 38) begin
        load_region(85);
        add_item(gdmq_pkg::OP_BUILD, int'($urandom_range(0, 63)),
                 int'($urandom_range(0, 63)), $urandom_range(0, 1) != 0);
      end else if (r < 95)
        add_item(gdmq_pkg::OP_QUERY, near_coord(sh_sx), near_coord(sh_sy),
                 $urandom_range(0, 1) != 0);
      else
        add_item(gdmq_pkg::OP_NONE, int'($urandom_range(0, 63)),
                 int'($urandom_range(0, 63)), $urandom_range(0, 1) != 0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: query before any build, unused code, corners
    add_item(gdmq_pkg::OP_QUERY, 0, 0, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 63, 63, 1'b1);
    add_item(gdmq_pkg::OP_NONE, 63, 0, 1'b1);
    wait (pending_items == 0 && expected_q.size() == 0);
    repeat (10) @(posedge clk_i);

    // start cell impassable: the build reaches nothing
    set_regs(1'b1, 2, 0, 0);
    add_item(gdmq_pkg::OP_LOAD, 0, 0, 1'b0);
    load_region(100);
    add_item(gdmq_pkg::OP_BUILD, 0, 0, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 0, 0, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 3, 2, 1'b0);
    // start passable, a wall to force detours and ring lookups
    add_item(gdmq_pkg::OP_LOAD, 0, 0, 1'b1);
    add_item(gdmq_pkg::OP_LOAD, 1, 1, 1'b0);
    add_item(gdmq_pkg::OP_LOAD, 2, 1, 1'b0);
    add_item(gdmq_pkg::OP_BUILD, 0, 0, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 0, 0, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 1, 1, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 2, 2, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 4, 4, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 5, 3, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 9, 9, 1'b0);
    add_item(gdmq_pkg::OP_LOAD, 63, 63, 1'b1);
    add_item(gdmq_pkg::OP_QUERY, 63, 63, 1'b0);
    drain();

    // four-way moves in the far corner, then a zero-radius region
    set_regs(1'b0, 3, 63, 63);
    load_region(80);
    add_item(gdmq_pkg::OP_BUILD, 0, 0, 1'b0);
    random_items(12);
    drain();

    set_regs(1'b1, 0, 10, 10);
    load_region(100);
    add_item(gdmq_pkg::OP_BUILD, 0, 0, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 10, 10, 1'b0);
    add_item(gdmq_pkg::OP_QUERY, 14, 6, 1'b0);
    random_items(6);
    drain();

    // long receiver hold-off while queries keep coming
    set_regs(1'b1, 2, 20, 40);
    load_region(85);
    add_item(gdmq_pkg::OP_BUILD, 0, 0, 1'b0);
    drain();
    hold_go = 1'b1;
    for (int i = 0; i < 16; i++)
      add_item(gdmq_pkg::OP_QUERY, near_coord(20), near_coord(40), 1'b0);
    random_items(6);
    drain();

    // last part without idling
    quiet = 1'b1;
    set_regs(1'b0, 1, 2, 61);
    load_region(75);
    add_item(gdmq_pkg::OP_BUILD, 0, 0, 1'b0);
    random_items(10);
    drain();
    repeat (20) @(posedge clk_i);

    $display("checked %0d query results after %0d map builds across several register",
             queries_seen, builds_done);
    $display("settings, including a long receiver hold-off and an idle-free tail");
    if (mismatches == 0 && expected_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // generous watchdog
  initial begin
    #40ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
